### hdl/uorp_pkg.sv
// ----------------------------------------------------------------------------
// UART queue pair package
// Shared types, event codes, FSM states and the overflow marker table.
// ----------------------------------------------------------------------------
package uorp_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int MARKER_LEN_DEF  = 19;
  localparam int MCNT_W          = 5;

  localparam logic [2:0] KIND_LINE  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_READ  = 3'd2;
  localparam logic [2:0] KIND_TXRDY = 3'd3;
  localparam logic [2:0] KIND_FLUSH = 3'd4;

  localparam logic [7:0] MARKER_TEXT [32] = '{
    8'h3C, 8'h44, 8'h41, 8'h50, 8'h4C, 8'h69, 8'h6E, 8'h6B, 8'h3A, 8'h4F,
    8'h76, 8'h65, 8'h72, 8'h66, 8'h6C, 8'h6F, 8'h77, 8'h3E, 8'h0A, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00
  };

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
  } ev_t;

  typedef struct packed {
    logic       sent_valid;
    logic [7:0] sent_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic       rx_dropped;
    logic       marker_inserted;
    logic       tx_busy;
    logic [5:0] rx_count;
    logic [5:0] tx_free;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MARK,
    ST_FIN
  } state_t;

endpackage

### hdl/uorp_ram.sv
// ----------------------------------------------------------------------------
// UART queue byte memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module uorp_ram #(
  parameter int DEPTH = uorp_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  import uorp_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/uorp_ctrl.sv
// ----------------------------------------------------------------------------
// UART queue controller
// Event sequencer, ring pointers, overflow policy and result register.
// ----------------------------------------------------------------------------
module uorp_ctrl #(
  parameter int QUEUE_DEPTH = uorp_pkg::QUEUE_DEPTH_DEF,
  parameter int MARKER_LEN  = uorp_pkg::MARKER_LEN_DEF,
  parameter int PW          = $clog2(QUEUE_DEPTH)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           overflow_detect,
  input  logic           ev_valid,
  output logic           ev_stall,
  input  uorp_pkg::ev_t  ev_data,
  output logic           res_valid,
  input  logic           res_stall,
  output uorp_pkg::res_t res_data,
  output logic           rx_we,
  output logic [PW-1:0]  rx_waddr,
  output logic [7:0]     rx_wdata,
  output logic [PW-1:0]  rx_raddr,
  input  logic [7:0]     rx_rdata,
  output logic           tx_we,
  output logic [PW-1:0]  tx_waddr,
  output logic [7:0]     tx_wdata,
  output logic [PW-1:0]  tx_raddr,
  input  logic [7:0]     tx_rdata
);
  import uorp_pkg::*;

  state_t            state, state_next;
  logic [PW-1:0]     rx_head, rx_tail, tx_head, tx_tail;
  logic              busy_flag;
  logic [MCNT_W-1:0] mcnt;
  logic [2:0]        kind_q;
  res_t              res;
  res_t              res_init;
  res_t              res_out;

  logic [PW-1:0] rx_cnt, rx_fr, tx_cnt, tx_fr;
  logic          accept, slot_free, rx_fits, rx_exact, mark_last;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] q_count(input logic [PW-1:0] h,
                                            input logic [PW-1:0] t);
    return (h >= t) ? h - t : h + PW'(QUEUE_DEPTH) - t;
  endfunction

  function automatic logic [5:0] sat63(input logic [PW-1:0] v);
    logic [PW+6:0] w;
    w = (PW+7)'(v);
    return (w > (PW+7)'(63)) ? 6'd63 : w[5:0];
  endfunction

  assign accept    = ev_valid && !ev_stall;
  assign slot_free = !res_valid || !res_stall;
  assign rx_cnt    = q_count(rx_head, rx_tail);
  assign tx_cnt    = q_count(tx_head, tx_tail);
  assign rx_fr     = PW'(QUEUE_DEPTH - 1) - rx_cnt;
  assign tx_fr     = PW'(QUEUE_DEPTH - 1) - tx_cnt;
  assign rx_fits   = rx_fr > PW'(MARKER_LEN);
  assign rx_exact  = rx_fr == PW'(MARKER_LEN);
  assign mark_last = mcnt == MCNT_W'(MARKER_LEN - 1);

  always_comb begin
    res_init = '0;
    case (ev_data.kind)
      KIND_LINE: begin
        if (!rx_fits) begin
          if (overflow_detect) begin
            res_init.rx_dropped      = 1'b1;
            res_init.marker_inserted = rx_exact;
          end else begin
            res_init.rx_dropped = rx_cnt != '0;
          end
        end
      end
      KIND_WRITE: res_init.write_accepted = tx_fr != '0;
      KIND_READ:  res_init.read_valid     = rx_cnt != '0;
      KIND_TXRDY: res_init.sent_valid     = tx_cnt != '0;
      default: ;
    endcase
  end

  always_comb begin
    res_out          = res;
    res_out.tx_busy  = busy_flag;
    res_out.rx_count = sat63(rx_cnt);
    res_out.tx_free  = sat63(tx_fr);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (ev_data.kind == KIND_LINE && !rx_fits && overflow_detect && rx_exact) begin
            state_next = ST_MARK;
          end else if ((ev_data.kind == KIND_READ && rx_cnt != '0) ||
                       (ev_data.kind == KIND_TXRDY && tx_cnt != '0)) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_READ: state_next = ST_FIN;
      ST_MARK: begin
        if (mark_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ev_stall = 1'b1;
    rx_we    = 1'b0;
    rx_wdata = ev_data.data_byte;
    tx_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        ev_stall = 1'b0;
        rx_we    = accept && ev_data.kind == KIND_LINE && (rx_fits || !overflow_detect);
        tx_we    = accept && ev_data.kind == KIND_WRITE && tx_fr != '0;
      end
      ST_MARK: begin
        rx_we    = 1'b1;
        rx_wdata = MARKER_TEXT[mcnt];
      end
      default: ;
    endcase
  end

  assign rx_waddr = rx_head;
  assign rx_raddr = rx_tail;
  assign tx_waddr = tx_head;
  assign tx_wdata = ev_data.data_byte;
  assign tx_raddr = tx_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rx_head   <= '0;
      rx_tail   <= '0;
      tx_head   <= '0;
      tx_tail   <= '0;
      busy_flag <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && slot_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res    <= res_init;
            kind_q <= ev_data.kind;
            mcnt   <= '0;
            case (ev_data.kind)
              KIND_LINE: begin
                if (rx_fits) begin
                  rx_head <= ptr_inc(rx_head);
                end else if (!overflow_detect) begin
                  rx_head <= ptr_inc(rx_head);
                  if (rx_cnt != '0) begin
                    rx_tail <= ptr_inc(rx_tail);
                  end
                end
              end
              KIND_WRITE: begin
                if (tx_fr != '0) begin
                  tx_head <= ptr_inc(tx_head);
                end
              end
              KIND_READ: begin
                if (rx_cnt != '0) begin
                  rx_tail <= ptr_inc(rx_tail);
                end
              end
              KIND_TXRDY: begin
                if (tx_cnt != '0) begin
                  tx_tail   <= ptr_inc(tx_tail);
                  busy_flag <= 1'b1;
                end else begin
                  busy_flag <= 1'b0;
                end
              end
              KIND_FLUSH: begin
                rx_head   <= '0;
                rx_tail   <= '0;
                tx_head   <= '0;
                tx_tail   <= '0;
                busy_flag <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          if (kind_q == KIND_READ) begin
            res.read_byte <= rx_rdata;
          end else begin
            res.sent_byte <= tx_rdata;
          end
        end
        ST_MARK: begin
          rx_head <= ptr_inc(rx_head);
          mcnt    <= mcnt + 1'b1;
        end
        ST_FIN: begin
          if (slot_free) begin
            res_data <= res_out;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### hdl/uart_rx_tx_fifo_overflow_policy_unit.sv
// Sequencing: most events go from idle through the finish state to the result
// register; a read or send first passes a queue memory read state, and a marker
// first writes all MARKER_LEN marker bytes. Events are taken one at a time, only
// in idle; the next event is taken while the result waits.
// Reset: synchronous; clears pointers, busy flag and the detect register.
// Queue memories are not cleared.
// ----------------------------------------------------------------------------
// UART queue pair with receive overflow policy
// Receive and transmit byte rings with marker insertion or drop-oldest.
// ----------------------------------------------------------------------------
module uart_rx_tx_fifo_overflow_policy_unit #(
  parameter int QUEUE_DEPTH = uorp_pkg::QUEUE_DEPTH_DEF,
  parameter int MARKER_LEN  = uorp_pkg::MARKER_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           ev_valid,
  output logic           ev_stall,
  input  uorp_pkg::ev_t  ev_data,
  output logic           res_valid,
  input  logic           res_stall,
  output uorp_pkg::res_t res_data
);
  import uorp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic          overflow_detect;
  logic          rx_we, tx_we;
  logic [PW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [7:0]    rx_wdata, rx_rdata, tx_wdata, tx_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_detect <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      overflow_detect <= cfg_data;
    end
  end

  uorp_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .MARKER_LEN (MARKER_LEN),
    .PW         (PW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .overflow_detect(overflow_detect),
    .ev_valid       (ev_valid),
    .ev_stall       (ev_stall),
    .ev_data        (ev_data),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res_data       (res_data),
    .rx_we          (rx_we),
    .rx_waddr       (rx_waddr),
    .rx_wdata       (rx_wdata),
    .rx_raddr       (rx_raddr),
    .rx_rdata       (rx_rdata),
    .tx_we          (tx_we),
    .tx_waddr       (tx_waddr),
    .tx_wdata       (tx_wdata),
    .tx_raddr       (tx_raddr),
    .tx_rdata       (tx_rdata)
  );

  uorp_ram #(.DEPTH(QUEUE_DEPTH), .AW(PW)) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(rx_waddr),
    .wdata(rx_wdata),
    .raddr(rx_raddr),
    .rdata(rx_rdata)
  );

  uorp_ram #(.DEPTH(QUEUE_DEPTH), .AW(PW)) u_tx_ram (
    .clk  (clk),
    .we   (tx_we),
    .waddr(tx_waddr),
    .wdata(tx_wdata),
    .raddr(tx_raddr),
    .rdata(tx_rdata)
  );

endmodule

### hdl/uorp_chk.sv
// ----------------------------------------------------------------------------
// UART queue pair port checker
// Port-level properties of the event and result channels.
// ----------------------------------------------------------------------------
module uorp_chk (
  input logic           clk,
  input logic           rst,
  input logic           ev_valid,
  input logic           ev_stall,
  input logic           res_valid,
  input logic           res_stall,
  input uorp_pkg::res_t res_data
);
  import uorp_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_stall |=> ev_stall)
    else $error("event taken while previous event still in work");

  a_marker_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.marker_inserted |-> res_data.rx_dropped)
    else $error("marker queued without dropping the line byte");

  a_single_action: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_data.sent_valid, res_data.read_valid,
                            res_data.write_accepted, res_data.marker_inserted}))
    else $error("result reports more than one queue action");

endmodule

bind uart_rx_tx_fifo_overflow_policy_unit uorp_chk u_chk (.*);

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART queue pair testbench
// Drives receive, host-write, host-read, transmitter-ready and flush events
// through the event channel with random gaps and result stalls. Each result is
// checked field by field against an in-bench model of both byte rings and the
// receive overflow policy, under both settings of the detect register.
// ----------------------------------------------------------------------------
module tb;
  import uorp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = MARKER_LEN_DEF + 8;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 255;

  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  typedef enum int {
    MODE_FILL_RX,
    MODE_DRAIN_RX,
    MODE_FILL_TX,
    MODE_DRAIN_TX,
    MODE_MIXED
  } traffic_mode_t;

  class uart_queue_scoreboard;
    logic [7:0] rx_mem [QUEUE_DEPTH_DEF];
    logic [7:0] tx_mem [QUEUE_DEPTH_DEF];
    logic [5:0] rx_wr, rx_rd, tx_wr, tx_rd;
    logic       busy;
    logic       detect;
    res_t       expected_q [$];
    int         errors;

    function void reset_state();
      rx_wr  = '0;
      rx_rd  = '0;
      tx_wr  = '0;
      tx_rd  = '0;
      busy   = 1'b0;
      detect = 1'b0;
      errors = 0;
      expected_q.delete();
    endfunction

    function void set_detect(logic v);
      detect = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_rx(logic [7:0] b);
      rx_mem[rx_wr] = b;
      rx_wr++;
    endfunction

    function void note_event(ev_t e);
      res_t       r;
      logic [5:0] rx_used;
      logic [5:0] rx_space;
      logic [5:0] tx_space;
      int         i;
      r        = '0;
      rx_used  = rx_wr - rx_rd;
      rx_space = 6'd63 - rx_used;
      tx_space = 6'd63 - (tx_wr - tx_rd);
      case (e.kind)
        KIND_LINE: begin
          if (rx_space > MARKER_LEN_DEF) begin
            push_rx(e.data_byte);
          end else if (detect) begin
            if (rx_space == MARKER_LEN_DEF) begin
              for (i = 0; i < MARKER_LEN_DEF; i++) push_rx(MARKER_TEXT[i & 31]);
              r.marker_inserted = 1'b1;
            end
            r.rx_dropped = 1'b1;
          end else begin
            if (rx_used != 0) begin
              rx_rd++;
              r.rx_dropped = 1'b1;
            end
            push_rx(e.data_byte);
          end
        end
        KIND_WRITE: begin
          if (tx_space != 0) begin
            tx_mem[tx_wr] = e.data_byte;
            tx_wr++;
            r.write_accepted = 1'b1;
          end
        end
        KIND_READ: begin
          if (rx_used != 0) begin
            r.read_byte  = rx_mem[rx_rd];
            r.read_valid = 1'b1;
            rx_rd++;
          end
        end
        KIND_TXRDY: begin
          if (tx_wr != tx_rd) begin
            r.sent_byte  = tx_mem[tx_rd];
            r.sent_valid = 1'b1;
            tx_rd++;
            busy = 1'b1;
          end else begin
            busy = 1'b0;
          end
        end
        KIND_FLUSH: begin
          rx_wr = '0;
          rx_rd = '0;
          tx_wr = '0;
          tx_rd = '0;
          busy  = 1'b0;
        end
        default: ;
      endcase
      r.tx_busy  = busy;
      r.rx_count = rx_wr - rx_rd;
      r.tx_free  = 6'd63 - (tx_wr - tx_rd);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no event outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("sent_valid", want.sent_valid, got.sent_valid);
      compare_field("sent_byte", want.sent_byte, got.sent_byte);
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("write_accepted", want.write_accepted, got.write_accepted);
      compare_field("rx_dropped", want.rx_dropped, got.rx_dropped);
      compare_field("marker_inserted", want.marker_inserted, got.marker_inserted);
      compare_field("tx_busy", want.tx_busy, got.tx_busy);
      compare_field("rx_count", want.rx_count, got.rx_count);
      compare_field("tx_free", want.tx_free, got.tx_free);
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;
  logic ev_valid  = 1'b0;
  logic ev_stall;
  ev_t  ev_data   = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  bit   calm        = 1'b0;
  int   idle_cycles = 0;

  uart_queue_scoreboard sb;

  uart_rx_tx_fifo_overflow_policy_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .ev_valid  (ev_valid),
    .ev_stall  (ev_stall),
    .ev_data   (ev_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic ev_t random_event(traffic_mode_t mode);
    ev_t e;
    int  r;
    r           = $urandom_range(0, 99);
    e.data_byte = 8'($urandom_range(0, 255));
    case (mode)
      MODE_FILL_RX:  e.kind = (r < 85) ? KIND_LINE : (r < 95) ? KIND_READ : KIND_TXRDY;
      MODE_DRAIN_RX: e.kind = (r < 70) ? KIND_READ : (r < 90) ? KIND_LINE : KIND_WRITE;
      MODE_FILL_TX:  e.kind = (r < 80) ? KIND_WRITE : (r < 90) ? KIND_TXRDY : KIND_LINE;
      MODE_DRAIN_TX: e.kind = (r < 70) ? KIND_TXRDY : (r < 90) ? KIND_WRITE : KIND_READ;
      default: begin
        if (r < 3) e.kind = KIND_FLUSH;
        else if (r < 9) e.kind = KIND_RSVD5 + 3'($urandom_range(0, 2));
        else e.kind = 3'($urandom_range(0, 3));
      end
    endcase
    return e;
  endfunction

  task automatic send_event(input ev_t e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_data  <= e;
    do @(posedge clk); while (ev_stall);
    sb.note_event(e);
  endtask

  task automatic settle_and_configure(input logic v);
    ev_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_detect(v);
  endtask

  // Result side stall pattern
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      res_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res_data);
  end

  always @(posedge clk) begin
    if ((ev_valid && !ev_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    ev_t           directed [$];
    traffic_mode_t mode;
    int            sent;
    int            burst;
    int            phase;
    sb = new;
    sb.reset_state();
    directed.push_back('{kind: KIND_READ,  data_byte: 8'h00});
    directed.push_back('{kind: KIND_TXRDY, data_byte: 8'h00});
    directed.push_back('{kind: KIND_LINE,  data_byte: 8'h00});
    directed.push_back('{kind: KIND_LINE,  data_byte: 8'hFF});
    directed.push_back('{kind: KIND_LINE,  data_byte: 8'hA5});
    directed.push_back('{kind: KIND_READ,  data_byte: 8'hFF});
    directed.push_back('{kind: KIND_READ,  data_byte: 8'h00});
    directed.push_back('{kind: KIND_WRITE, data_byte: 8'h00});
    directed.push_back('{kind: KIND_WRITE, data_byte: 8'hFF});
    directed.push_back('{kind: KIND_TXRDY, data_byte: 8'h5A});
    directed.push_back('{kind: KIND_TXRDY, data_byte: 8'h00});
    directed.push_back('{kind: KIND_TXRDY, data_byte: 8'h00});
    directed.push_back('{kind: KIND_RSVD5, data_byte: 8'h5A});
    directed.push_back('{kind: KIND_RSVD6, data_byte: 8'hFF});
    directed.push_back('{kind: KIND_RSVD7, data_byte: 8'h00});
    directed.push_back('{kind: KIND_WRITE, data_byte: 8'h3C});
    directed.push_back('{kind: KIND_LINE,  data_byte: 8'h11});
    directed.push_back('{kind: KIND_FLUSH, data_byte: 8'hFF});
    directed.push_back('{kind: KIND_READ,  data_byte: 8'h00});
    directed.push_back('{kind: KIND_TXRDY, data_byte: 8'h00});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_event(directed[i]);

    for (phase = 0; phase < PHASES; phase++) begin
      settle_and_configure(phase % 2 == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        mode  = traffic_mode_t'($urandom_range(0, 4));
        calm  = ($urandom_range(0, 4) == 0);
        burst = $urandom_range(40, 120);
        if (burst > PHASE_ITEMS - sent) burst = PHASE_ITEMS - sent;
        repeat (burst) send_event(random_event(mode));
        sent += burst;
      end
    end

    calm = 1'b0;
    ev_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
